[rtl/bb3_pkg.sv]
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and helpers of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int SIZE_W  = 11;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
    localparam int ORow_W  = $clog2(MAX_HEIGHT);
    localparam int PIX_W   = 32;
    localparam int RGB_W   = 24;
    localparam int SUM_W   = 12;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(800);
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(600);

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // floor(x / 9) for x below 2304
    localparam logic [12:0] DIV9_RECIP = 13'd7282;
    localparam int          DIV9_SHIFT = 16;

    typedef logic [RGB_W-1:0]  pixel_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [ORow_W-1:0] orow_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } tap_mask_t;

    function automatic logic [7:0] div9(input sum_t x);
        logic [SUM_W+12:0] prod;
        begin
            prod = (SUM_W + 13)'(x) * (SUM_W + 13)'(DIV9_RECIP);
            div9 = prod[DIV9_SHIFT+7:DIV9_SHIFT];
        end
    endfunction

    function automatic size_t clamp_size(input size_t v, input size_t max_v);
        begin
            if (v == '0)
            begin
                clamp_size = size_t'(1);
            end
            else if (v > max_v)
            begin
                clamp_size = max_v;
            end
            else
            begin
                clamp_size = v;
            end
        end
    endfunction

endpackage

[rtl/bb3_if.sv]
// ----------------------------------------------------------------------------
// bb3 channel interfaces
// Valid/ready channels for pixel input, blurred output and register writes.
// ----------------------------------------------------------------------------
interface bb3_in_if import bb3_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [PIX_W-1:0] in_pixel;

    modport source (output valid, output func, output in_pixel, input ready);
    modport sink   (input valid, input func, input in_pixel, output ready);
endinterface

interface bb3_out_if import bb3_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             end_of_frame;

    modport source (output valid, output out_pixel, output end_of_frame, input ready);
    modport sink   (input valid, input out_pixel, input end_of_frame, output ready);
endinterface

interface bb3_cfg_if import bb3_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/box_blur_3x3_rgb.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur over raster-order RGBA8888 frames, alpha forced opaque.
// Throughput: one item per clock while the output is not stalled; each line
// memory takes one read and one write per cycle, and the write of an item is
// forwarded to a read of the same column. The item completing a window is
// registered, then its sums; it comes frame_width+1 items after the source pixel.
// Reset: counters and window clear, sizes return to 800x600; line memories keep
// their contents and are not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb import bb3_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    bb3_in_if.sink   in_ch,
    bb3_out_if.source out_ch,
    bb3_cfg_if.sink  cfg
);

    size_t  fw_reg;
    size_t  fh_reg;
    size_t  w_eff;
    size_t  h_eff;

    col_t   in_col_reg;
    row_t   in_row_reg;
    col_t   out_col_reg;
    orow_t  out_row_reg;
    col_t   in_col_next;
    row_t   in_row_next;
    col_t   out_col_next;
    orow_t  out_row_next;

    logic   s1_v_reg;
    logic   fwd_reg;
    pixel_t s1_pix_reg;
    pixel_t last_mid_reg;
    pixel_t last_pix_reg;
    pixel_t rd_two_reg;
    pixel_t rd_above_reg;

    logic   o_v_reg;
    logic   eof_reg;
    sum_t   sum_r_reg;
    sum_t   sum_g_reg;
    sum_t   sum_b_reg;

    pixel_t mem_two   [MAX_WIDTH];
    pixel_t mem_above [MAX_WIDTH];

    logic      in_acc;
    logic      s2_free;
    logic      s1_go;
    logic      s1_emit;
    logic      in_wrap;
    logic      out_col_end;
    logic      out_row_end;
    logic      last;
    col_t      rd_addr;
    pixel_t    top_eff;
    pixel_t    mid_eff;
    tap_mask_t mask;
    sum_t      sum_r;
    sum_t      sum_g;
    sum_t      sum_b;

    assign w_eff = clamp_size(fw_reg, SIZE_W'(MAX_WIDTH));
    assign h_eff = clamp_size(fh_reg, SIZE_W'(MAX_HEIGHT));

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= RESET_WIDTH;
            fh_reg <= RESET_HEIGHT;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == REG_FRAME_WIDTH)
            begin
                fw_reg <= cfg.data;
            end
            else if (cfg.index == REG_FRAME_HEIGHT)
            begin
                fh_reg <= cfg.data;
            end
        end
    end

    assign top_eff = fwd_reg ? last_mid_reg : rd_two_reg;
    assign mid_eff = fwd_reg ? last_pix_reg : rd_above_reg;

    assign s1_emit = (in_row_reg >= ROW_W'(2)) ||
                     ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign s2_free = !o_v_reg || out_ch.ready;
    assign s1_go   = s1_v_reg && (!s1_emit || s2_free);
    assign in_ch.ready = !s1_v_reg || s1_go;
    assign in_acc  = in_ch.valid && in_ch.ready;

    assign in_wrap     = (SIZE_W'(in_col_reg) + SIZE_W'(1)) >= w_eff;
    assign out_col_end = (SIZE_W'(out_col_reg) + SIZE_W'(1)) >= w_eff;
    assign out_row_end = (SIZE_W'(out_row_reg) + SIZE_W'(1)) >= h_eff;
    assign last        = s1_emit && out_col_end && out_row_end;

    always_comb
    begin
        in_col_next  = in_wrap ? '0 : in_col_reg + COL_W'(1);
        in_row_next  = in_row_reg;
        if (in_wrap && (in_row_reg < ROW_W'(MAX_HEIGHT + 1)))
        begin
            in_row_next = in_row_reg + ROW_W'(1);
        end
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (s1_emit)
        begin
            if (out_col_end)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + ORow_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
        if (last)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    assign rd_addr = s1_v_reg ? in_col_next : in_col_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rd_two_reg   <= mem_two[rd_addr];
            rd_above_reg <= mem_above[rd_addr];
        end
        if (s1_go)
        begin
            mem_two[in_col_reg]   <= mid_eff;
            mem_above[in_col_reg] <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            fwd_reg     <= 1'b0;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            o_v_reg     <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_v_reg <= 1'b1;
                fwd_reg  <= s1_go && (in_col_reg == rd_addr);
            end
            else if (s1_go)
            begin
                s1_v_reg <= 1'b0;
            end
            if (s1_go)
            begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
            if (s1_go && s1_emit)
            begin
                o_v_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                o_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg <= in_ch.func ? '0 : in_ch.in_pixel[31:8];
        end
        if (s1_go)
        begin
            last_mid_reg <= mid_eff;
            last_pix_reg <= s1_pix_reg;
        end
        if (s1_go && s1_emit)
        begin
            sum_r_reg <= sum_r;
            sum_g_reg <= sum_g;
            sum_b_reg <= sum_b;
            eof_reg   <= last;
        end
    end

    assign mask.top    = (out_row_reg == '0);
    assign mask.bottom = out_row_end;
    assign mask.left   = (out_col_reg == '0);
    assign mask.right  = out_col_end;

    bb3_window u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_go),
        .col_top  (top_eff),
        .col_mid  (mid_eff),
        .col_bot  (s1_pix_reg),
        .mask     (mask),
        .sum_r    (sum_r),
        .sum_g    (sum_g),
        .sum_b    (sum_b)
    );

    assign out_ch.valid        = o_v_reg;
    assign out_ch.out_pixel    = {div9(sum_r_reg), div9(sum_g_reg), div9(sum_b_reg),
                                  ALPHA_OPAQUE};
    assign out_ch.end_of_frame = eof_reg;

endmodule

[rtl/bb3_window.sv]
// ----------------------------------------------------------------------------
// bb3_window
// 3x3 tap window with border-masked per-channel sums of the shifted window.
// ----------------------------------------------------------------------------
module bb3_window import bb3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      shift_en,
    input  pixel_t    col_top,
    input  pixel_t    col_mid,
    input  pixel_t    col_bot,
    input  tap_mask_t mask,
    output sum_t      sum_r,
    output sum_t      sum_g,
    output sum_t      sum_b
);

    pixel_t taps_reg  [3][3];
    pixel_t taps_next [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            taps_next[r][0] = taps_reg[r][1];
            taps_next[r][1] = taps_reg[r][2];
        end
        taps_next[0][2] = col_top;
        taps_next[1][2] = col_mid;
        taps_next[2][2] = col_bot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    taps_reg[r][c] <= '0;
                end
            end
        end
        else if (shift_en)
        begin
            taps_reg <= taps_next;
        end
    end

    always_comb
    begin
        logic [2:0] row_en;
        logic [2:0] col_en;
        row_en = {!mask.bottom, 1'b1, !mask.top};
        col_en = {!mask.right, 1'b1, !mask.left};
        sum_r  = '0;
        sum_g  = '0;
        sum_b  = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (row_en[r] && col_en[c])
                begin
                    sum_r = sum_r + SUM_W'(taps_next[r][c][23:16]);
                    sum_g = sum_g + SUM_W'(taps_next[r][c][15:8]);
                    sum_b = sum_b + SUM_W'(taps_next[r][c][7:0]);
                end
            end
        end
    end

endmodule

[rtl/bb3_checker.sv]
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level assertions for the box blur, bound to the top level.
// ----------------------------------------------------------------------------
module bb3_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_pixel,
    input logic        end_of_frame,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel))
        else $error("output beat changed while stalled");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_pixel[7:0] == 8'hFF)
        else $error("output alpha not opaque");

    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output side is ready");

    a_frame_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && end_of_frame |=> !out_valid)
        else $error("output beat right after end of frame");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write stalled");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_pixel    (out_ch.out_pixel),
    .end_of_frame (out_ch.end_of_frame),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready)
);

[tb/box_blur_3x3_rgb_tb.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_tb
// Streams RGBA frames of many sizes into the 3x3 box blur, flush ticks after
// each frame, and compares every blurred pixel and end-of-frame flag with a
// running in-bench calculation of the window. Sizes are reprogrammed between
// frames, including the clamped zero values. Both channels idle in random
// bursts.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_tb;
    import bb3_pkg::*;

    localparam logic        FUNC_PIXEL     = 1'b0;
    localparam logic        FUNC_FLUSH     = 1'b1;
    localparam int unsigned BLUR_TAPS      = 9;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned RANDOM_ITEMS   = 1200;
    localparam int unsigned CALM_TAIL      = 1000;

    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZERO} fill_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } blur_result_t;

    class blurred_frame;
        size_t        width_reg;
        size_t        height_reg;
        pixel_t       line_above [MAX_WIDTH];
        pixel_t       line_two_above [MAX_WIDTH];
        pixel_t       taps [3][3];
        int unsigned  in_col;
        int unsigned  in_row;
        int unsigned  out_col;
        int unsigned  out_row;
        blur_result_t pending_pixels [$];
        int unsigned  errors;

        function new();
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            foreach (line_above[i])
            begin
                line_above[i]     = '0;
                line_two_above[i] = '0;
            end
            foreach (taps[r, c])
            begin
                taps[r][c] = '0;
            end
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            errors  = 0;
        endfunction

        static function int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned max_v);
            if (v == '0)
            begin
                return 1;
            end
            if (v > max_v)
            begin
                return max_v;
            end
            return v;
        endfunction

        function bit drained();
            return pending_pixels.size() == 0;
        endfunction

        function void write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
            if (idx == REG_FRAME_WIDTH)
            begin
                width_reg = data;
            end
            else if (idx == REG_FRAME_HEIGHT)
            begin
                height_reg = data;
            end
        endfunction

        function void take_item(logic f, logic [PIX_W-1:0] p);
            int unsigned  w;
            int unsigned  h;
            int unsigned  col;
            int unsigned  sum_r;
            int unsigned  sum_g;
            int unsigned  sum_b;
            int           r;
            int           c;
            pixel_t       fresh;
            pixel_t       top;
            pixel_t       mid;
            pixel_t       v;
            bit           emit;
            blur_result_t res;
            w     = eff_size(width_reg, MAX_WIDTH);
            h     = eff_size(height_reg, MAX_HEIGHT);
            fresh = (f == FUNC_FLUSH) ? pixel_t'(0) : p[PIX_W-1:8];
            col   = (in_col < MAX_WIDTH) ? in_col : 0;
            top   = line_two_above[col];
            mid   = line_above[col];
            line_two_above[col] = mid;
            line_above[col]     = fresh;
            for (r = 0; r < 3; r++)
            begin
                taps[r][0] = taps[r][1];
                taps[r][1] = taps[r][2];
            end
            taps[0][2] = top;
            taps[1][2] = mid;
            taps[2][2] = fresh;

            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            if (in_col + 1 >= w)
            begin
                in_col = 0;
                if (in_row < MAX_HEIGHT + 1)
                begin
                    in_row++;
                end
            end
            else
            begin
                in_col++;
            end
            if (!emit)
            begin
                return;
            end

            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (r = 0; r < 3; r++)
            begin
                if ((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h))
                begin
                    continue;
                end
                for (c = 0; c < 3; c++)
                begin
                    if ((c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w))
                    begin
                        continue;
                    end
                    v = taps[r][c];
                    sum_r += v[23:16];
                    sum_g += v[15:8];
                    sum_b += v[7:0];
                end
            end
            res.pixel = {8'(sum_r / BLUR_TAPS), 8'(sum_g / BLUR_TAPS),
                         8'(sum_b / BLUR_TAPS), ALPHA_OPAQUE};
            res.last  = (out_col + 1 >= w) && (out_row + 1 >= h);
            pending_pixels.push_back(res);

            if (res.last)
            begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
            end
            else if (out_col + 1 >= w)
            begin
                out_col = 0;
                out_row++;
            end
            else
            begin
                out_col++;
            end
        endfunction

        function void match_pixel(logic [PIX_W-1:0] p, logic eof);
            blur_result_t res;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $error("out_pixel: expected none, actual %h", p);
                return;
            end
            res = pending_pixels.pop_front();
            if (p !== res.pixel)
            begin
                errors++;
                $error("out_pixel: expected %h, actual %h", res.pixel, p);
            end
            if (eof !== res.last)
            begin
                errors++;
                $error("end_of_frame: expected %b, actual %b", res.last, eof);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    bit          quiet;
    int unsigned idle_cycles;

    blurred_frame frame_calc = new();

    bb3_in_if  in_ch ();
    bb3_out_if out_ch ();
    bb3_cfg_if cfg_ch ();

    box_blur_3x3_rgb i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_ch.valid && out_ch.ready)
            begin
                frame_calc.match_pixel(out_ch.out_pixel, out_ch.end_of_frame);
                moved = 1'b1;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                frame_calc.take_item(in_ch.func, in_ch.in_pixel);
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                frame_calc.write_size(cfg_ch.index, cfg_ch.data);
                moved = 1'b1;
            end
            if (moved)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("box_blur_3x3_rgb_tb: done, errors");
                    $finish;
                end
            end
        end
    end

    // output back-pressure
    initial
    begin
        int unsigned calm;
        calm = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (calm > 0)
            begin
                calm--;
            end
            else if ($urandom_range(0, 31) == 0)
            begin
                calm = $urandom_range(20, 80);
            end
            if (!quiet && calm == 0 && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_item(logic f, logic [PIX_W-1:0] p, bit gaps);
        if (gaps && !quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.func     <= f;
        in_ch.in_pixel <= p;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_frame_size(logic [SIZE_W-1:0] wd, logic [SIZE_W-1:0] hd, bit stray);
        @(posedge clk);
        while (!frame_calc.drained())
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (stray)
        begin
            cfg_beat(CFG_IDX_W'($urandom_range(REG_FRAME_HEIGHT + 1, 2**CFG_IDX_W - 1)),
                     SIZE_W'($urandom_range(0, 2**SIZE_W - 1)));
        end
        cfg_beat(REG_FRAME_WIDTH, wd);
        cfg_beat(REG_FRAME_HEIGHT, hd);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_frame(int unsigned w, int unsigned h, fill_t fill, bit flip, bit gaps);
        int unsigned      n;
        logic             f;
        logic [PIX_W-1:0] p;
        for (n = 0; n < w * h + w + 1; n++)
        begin
            f = (n < w * h) ? FUNC_PIXEL : FUNC_FLUSH;
            if (flip && $urandom_range(0, 7) == 0)
            begin
                f = ~f;
            end
            case (fill)
                FILL_ONES: p = '1;
                FILL_ZERO: p = '0;
                default:
                begin
                    p = $urandom;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        p = $urandom_range(0, 1) ? '1 : '0;
                    end
                end
            endcase
            send_item(f, p, gaps);
        end
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned      n;
        int unsigned      sent;
        int unsigned      w;
        int unsigned      h;
        logic [SIZE_W-1:0] wd;
        logic [SIZE_W-1:0] hd;
        logic             f;
        fill_t            fill;

        quiet           = 1'b0;
        idle_cycles     = 0;
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.func     <= FUNC_PIXEL;
        in_ch.in_pixel <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_FRAME_WIDTH;
        cfg_ch.data    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero sizes clamp to a single pixel
        load_frame_size('0, '0, 1'b1);
        run_frame(1, 1, FILL_ONES, 1'b0, 1'b1);

        // full-scale 3x3 with a flush in place of the center pixel and a pixel
        // in place of the last flush
        load_frame_size(SIZE_W'(3), SIZE_W'(3), 1'b0);
        for (n = 0; n < 13; n++)
        begin
            f = (n < 9) ? FUNC_PIXEL : FUNC_FLUSH;
            if (n == 4 || n == 12)
            begin
                f = ~f;
            end
            send_item(f, '1, 1'b1);
        end
        in_ch.valid <= 1'b0;

        load_frame_size(SIZE_W'(2), SIZE_W'(2), 1'b1);
        run_frame(2, 2, FILL_ZERO, 1'b0, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wd = ($urandom_range(0, 15) == 0) ? SIZE_W'(0) : SIZE_W'($urandom_range(1, 10));
            hd = ($urandom_range(0, 15) == 0) ? SIZE_W'(0) : SIZE_W'($urandom_range(1, 8));
            load_frame_size(wd, hd, $urandom_range(0, 5) == 0);
            w = blurred_frame::eff_size(wd, MAX_WIDTH);
            h = blurred_frame::eff_size(hd, MAX_HEIGHT);
            case ($urandom_range(0, 7))
                0:       fill = FILL_ONES;
                1:       fill = FILL_ZERO;
                default: fill = FILL_RANDOM;
            endcase
            run_frame(w, h, fill, $urandom_range(0, 5) == 0, $urandom_range(0, 2) != 0);
            sent += w * h + w + 1;
            if (sent >= CALM_TAIL)
            begin
                quiet = 1'b1;
            end
        end

        @(posedge clk);
        while (!frame_calc.drained())
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (frame_calc.errors == 0)
        begin
            $display("box_blur_3x3_rgb_tb: done, clean");
        end
        else
        begin
            $display("box_blur_3x3_rgb_tb: done, errors");
        end
        $finish;
    end

endmodule
